[rtl/core/mtaf_pkg.sv]
// shared types, constants and the arctangent table of the max triangle angle finder
// no dependencies; imported by every module of the block
package mtaf_pkg;

  localparam int POS_W        = 10;
  localparam int ANGLE_W      = 22;
  localparam int COORD_MAX_W  = 16;
  localparam int MIN_POINTS   = 3;
  localparam int DIG_W        = 8;
  localparam int Q_W          = 31;
  localparam int SQ_W         = 63;
  localparam int CW           = 34;

  localparam int MAX_POINTS_DEF   = 64;
  localparam int COORD_BITS_DEF   = 10;
  localparam int CORDIC_STEPS_DEF = 24;

  localparam logic [Q_W-1:0]        Q_ONE       = 31'h4000_0000;
  localparam logic signed [CW-1:0]  HALF_PI_Q30 = 34'sd1686629713;
  localparam logic [ANGLE_W-1:0]    ANGLE_MAX   = 22'd3294199;

  typedef enum logic [5:0] {
    ST_LOAD, ST_START, ST_A_CHK, ST_A_RD, ST_A_LD,
    ST_B_CHK, ST_B_RD, ST_B_LD, ST_B_SQX, ST_B_SQY, ST_B_LEN,
    ST_C_CHK, ST_C_RD, ST_C_LD, ST_C_SQX, ST_C_SQY, ST_C_DX, ST_C_DY, ST_C_LP,
    ST_C_DEC, ST_C_LHS, ST_C_RHS1, ST_C_RHS2, ST_C_CMP,
    ST_Q_TGT, ST_Q_SET, ST_Q_T1, ST_Q_T2, ST_Q_T3,
    ST_S_SQ, ST_S_INIT, ST_S_IT,
    ST_R_INIT, ST_R_IT, ST_R_FIN,
    ST_FIN, ST_MUL_WAIT
  } mtaf_state_e;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               too_few;
    logic               overflowed;
  } mtaf_res_t;

  // atan(2^-k) in units of 2^-30
  function automatic logic [29:0] atan_q30(input logic [4:0] k);
    logic [29:0] v;
    case (k)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/mtaf_mul.sv]
// shared digit-serial multiplier: p = a * b, one 8-bit digit of b per cycle, msb first
// depends on mtaf_pkg
module mtaf_mul #(
  parameter int AW = 73,
  parameter int BW = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             busy_o,
  output logic [AW+BW-1:0] p_o
);
  import mtaf_pkg::*;

  localparam int ND = BW / DIG_W;
  localparam int NW = $clog2(ND + 1);

  logic [AW-1:0]       a_q;
  logic [BW-1:0]       b_q;
  logic [AW+BW-1:0]    acc_q;
  logic [NW-1:0]       cnt_q;
  logic                busy_q;
  logic [AW+DIG_W-1:0] part;

  assign part   = a_q * b_q[BW-1 -: DIG_W];
  assign busy_o = busy_q;
  assign p_o    = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= NW'(ND);
    end else if (busy_q) begin
      cnt_q <= cnt_q - NW'(1);
      if (cnt_q == NW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // horner accumulation: shift in one digit weight per step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= (acc_q << DIG_W) + (AW+BW)'(part);
      b_q   <= b_q << DIG_W;
    end
  end

endmodule

[rtl/core/mtaf_seq.sv]
// point store, triple search, cosine bisection, square root and cordic sequencer
// depends on mtaf_pkg and mtaf_mul
module mtaf_seq #(
  parameter int MAX_POINTS   = mtaf_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS   = mtaf_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STEPS = mtaf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [COORD_BITS-1:0] px_i,
  input  logic [COORD_BITS-1:0] py_i,
  input  logic                  final_i,
  output logic                  ready_o,
  output logic                  res_valid_o,
  output mtaf_pkg::mtaf_res_t   res_o,
  input  logic                  res_ready_i
);
  import mtaf_pkg::*;

  localparam int DW   = COORD_BITS + 1;
  localparam int MW   = 2 * COORD_BITS + 1;
  localparam int LPW  = 2 * MW;
  localparam int BSRC = (MW > Q_W) ? MW : Q_W;
  localparam int BW   = ((BSRC + DIG_W - 1) / DIG_W) * DIG_W;
  localparam int AW   = LPW + BSRC;
  localparam int PW   = AW + BW;
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int IW   = $clog2(MAX_POINTS);
  localparam int KW   = $clog2(CORDIC_STEPS);

  mtaf_state_e state_q, state_d, ret_q, ret_d;

  logic [2*COORD_BITS-1:0] mem [MAX_POINTS];
  logic [2*COORD_BITS-1:0] rd_q;
  logic [IW-1:0]           rd_addr;

  logic [CNTW-1:0] cnt_q, ia_q, ib_q, ic_q;
  logic            ovf_q, bv_q;
  logic            cnt_full;

  logic [COORD_BITS-1:0] ax_q, ay_q;
  logic signed [DW-1:0]  x1_q, y1_q, x2_q, y2_q;
  logic [DW-1:0]         x1_mag, y1_mag, x2_mag, y2_mag;
  logic [MW-1:0]         l1_q, l2_q, l1_sum, l2_sum;
  logic signed [MW:0]    dot_q, bd_q, p_dot;
  logic [MW:0]           dot_mag, bd_mag;
  logic [LPW-1:0]        blp_q, lpn_q;
  logic [PW-1:0]         lhs_q, tgt_q;
  logic                  take, skip, smaller;

  logic [Q_W-1:0]  q_q, t_val, q_clamp;
  logic [4:0]      qbit_q;
  logic [SQ_W-1:0] v_q, r_q, sb_q, sq_try;
  logic            sq_ge;

  logic signed [CW-1:0] x_q, y_q, z_q, dx, dy, at, z_rnd;
  logic [KW-1:0]        k_q;
  logic                 rot;

  logic [ANGLE_W-1:0] angle_q;
  logic               few_q;

  logic          mul_start, mul_busy;
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [PW-1:0] mul_p;

  mtaf_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .p_o     (mul_p)
  );

  assign cnt_full = (cnt_q == CNTW'(MAX_POINTS));
  assign x1_mag   = x1_q[DW-1] ? DW'(-x1_q) : DW'(x1_q);
  assign y1_mag   = y1_q[DW-1] ? DW'(-y1_q) : DW'(y1_q);
  assign x2_mag   = x2_q[DW-1] ? DW'(-x2_q) : DW'(x2_q);
  assign y2_mag   = y2_q[DW-1] ? DW'(-y2_q) : DW'(y2_q);
  assign dot_mag  = dot_q[MW] ? (MW+1)'(-dot_q) : (MW+1)'(dot_q);
  assign bd_mag   = bd_q[MW] ? (MW+1)'(-bd_q) : (MW+1)'(bd_q);
  assign l1_sum   = l1_q + MW'(mul_p);
  assign l2_sum   = l2_q + MW'(mul_p);
  assign p_dot    = signed'((MW+1)'(mul_p));

  // sign classes settle the compare without products
  assign take    = !bv_q || (dot_q[MW] && !bd_q[MW]);
  assign skip    = bv_q && !dot_q[MW] && bd_q[MW];
  assign smaller = dot_q[MW] ? (lhs_q > mul_p) : (lhs_q < mul_p);

  assign t_val   = q_q | (Q_W'(1) << qbit_q);
  assign q_clamp = (q_q > Q_ONE) ? Q_ONE : q_q;
  assign sq_try  = r_q + sb_q;
  assign sq_ge   = v_q >= sq_try;

  assign dx    = y_q >>> k_q;
  assign dy    = x_q >>> k_q;
  assign at    = signed'(CW'(atan_q30(5'(k_q))));
  assign z_rnd = (z_q + 34'sd512) >>> 10;
  assign rot   = bd_q[MW] && (q_q != '0);

  assign res_o.angle      = angle_q;
  assign res_o.too_few    = few_q;
  assign res_o.overflowed = ovf_q;

  // next state
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      ST_LOAD:   if (load_i && final_i) state_d = ST_START;
      ST_START:  state_d = (cnt_q < CNTW'(MIN_POINTS)) ? ST_FIN : ST_A_CHK;
      ST_A_CHK: begin
        if (ia_q >= cnt_q) state_d = bv_q ? ST_Q_TGT : ST_FIN;
        else               state_d = ST_A_RD;
      end
      ST_A_RD:   state_d = ST_A_LD;
      ST_A_LD:   state_d = ST_B_CHK;
      ST_B_CHK: begin
        if (ib_q >= cnt_q)     state_d = ST_A_CHK;
        else if (ib_q != ia_q) state_d = ST_B_RD;
      end
      ST_B_RD:   state_d = ST_B_LD;
      ST_B_LD:   state_d = ST_B_SQX;
      ST_B_SQX:  begin state_d = ST_MUL_WAIT; ret_d = ST_B_SQY; end
      ST_B_SQY:  begin state_d = ST_MUL_WAIT; ret_d = ST_B_LEN; end
      ST_B_LEN:  state_d = (l1_sum == '0) ? ST_B_CHK : ST_C_CHK;
      ST_C_CHK: begin
        if (ic_q >= cnt_q)     state_d = ST_B_CHK;
        else if (ic_q != ia_q) state_d = ST_C_RD;
      end
      ST_C_RD:   state_d = ST_C_LD;
      ST_C_LD:   state_d = ST_C_SQX;
      ST_C_SQX:  begin state_d = ST_MUL_WAIT; ret_d = ST_C_SQY; end
      ST_C_SQY:  begin state_d = ST_MUL_WAIT; ret_d = ST_C_DX; end
      ST_C_DX: begin
        if (l2_sum == '0) state_d = ST_C_CHK;
        else begin state_d = ST_MUL_WAIT; ret_d = ST_C_DY; end
      end
      ST_C_DY:   begin state_d = ST_MUL_WAIT; ret_d = ST_C_LP; end
      ST_C_LP:   begin state_d = ST_MUL_WAIT; ret_d = ST_C_DEC; end
      ST_C_DEC: begin
        if (take || skip) state_d = ST_C_CHK;
        else begin state_d = ST_MUL_WAIT; ret_d = ST_C_LHS; end
      end
      ST_C_LHS:  begin state_d = ST_MUL_WAIT; ret_d = ST_C_RHS1; end
      ST_C_RHS1: begin state_d = ST_MUL_WAIT; ret_d = ST_C_RHS2; end
      ST_C_RHS2: begin state_d = ST_MUL_WAIT; ret_d = ST_C_CMP; end
      ST_C_CMP:  state_d = ST_C_CHK;
      ST_Q_TGT:  begin state_d = ST_MUL_WAIT; ret_d = ST_Q_SET; end
      ST_Q_SET:  state_d = ST_Q_T1;
      ST_Q_T1:   begin state_d = ST_MUL_WAIT; ret_d = ST_Q_T2; end
      ST_Q_T2:   begin state_d = ST_MUL_WAIT; ret_d = ST_Q_T3; end
      ST_Q_T3:   state_d = (qbit_q == '0) ? ST_S_SQ : ST_Q_T1;
      ST_S_SQ:   begin state_d = ST_MUL_WAIT; ret_d = ST_S_INIT; end
      ST_S_INIT: state_d = ST_S_IT;
      ST_S_IT:   if (sb_q == SQ_W'(1)) state_d = ST_R_INIT;
      ST_R_INIT: state_d = ST_R_IT;
      ST_R_IT:   if (k_q == KW'(CORDIC_STEPS - 1)) state_d = ST_R_FIN;
      ST_R_FIN:  state_d = ST_FIN;
      ST_FIN:    if (res_ready_i) state_d = ST_LOAD;
      ST_MUL_WAIT: if (!mul_busy) state_d = ret_q;
      default:   state_d = ST_LOAD;
    endcase
  end

  // outputs to the multiplier and the store
  always_comb begin
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    rd_addr     = ia_q[IW-1:0];
    ready_o     = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      ST_LOAD:   ready_o = 1'b1;
      ST_FIN:    res_valid_o = 1'b1;
      ST_B_RD:   rd_addr = ib_q[IW-1:0];
      ST_C_RD:   rd_addr = ic_q[IW-1:0];
      ST_B_SQX:  begin mul_start = 1'b1; mul_a = AW'(x1_mag); mul_b = BW'(x1_mag); end
      ST_B_SQY:  begin mul_start = 1'b1; mul_a = AW'(y1_mag); mul_b = BW'(y1_mag); end
      ST_C_SQX:  begin mul_start = 1'b1; mul_a = AW'(x2_mag); mul_b = BW'(x2_mag); end
      ST_C_SQY:  begin mul_start = 1'b1; mul_a = AW'(y2_mag); mul_b = BW'(y2_mag); end
      ST_C_DX: begin
        mul_start = (l2_sum != '0);
        mul_a     = AW'(x1_mag);
        mul_b     = BW'(x2_mag);
      end
      ST_C_DY:   begin mul_start = 1'b1; mul_a = AW'(y1_mag); mul_b = BW'(y2_mag); end
      ST_C_LP:   begin mul_start = 1'b1; mul_a = AW'(l1_q); mul_b = BW'(l2_q); end
      ST_C_DEC: begin
        mul_start = !(take || skip);
        mul_a     = AW'(blp_q);
        mul_b     = BW'(dot_mag);
      end
      ST_C_LHS:  begin mul_start = 1'b1; mul_a = AW'(mul_p); mul_b = BW'(dot_mag); end
      ST_C_RHS1: begin mul_start = 1'b1; mul_a = AW'(lpn_q); mul_b = BW'(bd_mag); end
      ST_C_RHS2: begin mul_start = 1'b1; mul_a = AW'(mul_p); mul_b = BW'(bd_mag); end
      ST_Q_TGT:  begin mul_start = 1'b1; mul_a = AW'(bd_mag); mul_b = BW'(bd_mag); end
      ST_Q_T1:   begin mul_start = 1'b1; mul_a = AW'(blp_q); mul_b = BW'(t_val); end
      ST_Q_T2:   begin mul_start = 1'b1; mul_a = AW'(mul_p); mul_b = BW'(t_val); end
      ST_S_SQ:   begin mul_start = 1'b1; mul_a = AW'(q_clamp); mul_b = BW'(q_clamp); end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD && load_i && !cnt_full) begin
      mem[cnt_q[IW-1:0]] <= {py_i, px_i};
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      ret_q   <= ST_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      bv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      case (state_q)
        ST_LOAD: begin
          if (load_i) begin
            if (!cnt_full) cnt_q <= cnt_q + CNTW'(1);
            else           ovf_q <= 1'b1;
          end
        end
        ST_C_DEC: if (take) bv_q <= 1'b1;
        ST_C_CMP: if (smaller) bv_q <= 1'b1;
        ST_FIN: begin
          if (res_ready_i) begin
            cnt_q <= '0;
            ovf_q <= 1'b0;
            bv_q  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_START: begin
        few_q   <= (cnt_q < CNTW'(MIN_POINTS));
        angle_q <= '0;
        ia_q    <= '0;
      end
      ST_A_CHK: if (ia_q < cnt_q) ib_q <= '0;
      ST_A_LD: begin
        ax_q <= rd_q[COORD_BITS-1:0];
        ay_q <= rd_q[2*COORD_BITS-1:COORD_BITS];
      end
      ST_B_CHK: begin
        if (ib_q >= cnt_q)     ia_q <= ia_q + CNTW'(1);
        else if (ib_q == ia_q) ib_q <= ib_q + CNTW'(1);
      end
      ST_B_LD: begin
        x1_q <= signed'({1'b0, rd_q[COORD_BITS-1:0]}) - signed'({1'b0, ax_q});
        y1_q <= signed'({1'b0, rd_q[2*COORD_BITS-1:COORD_BITS]}) - signed'({1'b0, ay_q});
      end
      ST_B_SQY: l1_q <= MW'(mul_p);
      ST_B_LEN: begin
        l1_q <= l1_sum;
        if (l1_sum == '0) ib_q <= ib_q + CNTW'(1);
        else              ic_q <= ib_q + CNTW'(1);
      end
      ST_C_CHK: begin
        if (ic_q >= cnt_q)     ib_q <= ib_q + CNTW'(1);
        else if (ic_q == ia_q) ic_q <= ic_q + CNTW'(1);
      end
      ST_C_LD: begin
        x2_q <= signed'({1'b0, rd_q[COORD_BITS-1:0]}) - signed'({1'b0, ax_q});
        y2_q <= signed'({1'b0, rd_q[2*COORD_BITS-1:COORD_BITS]}) - signed'({1'b0, ay_q});
      end
      ST_C_SQY: l2_q <= MW'(mul_p);
      ST_C_DX: begin
        l2_q <= l2_sum;
        if (l2_sum == '0) ic_q <= ic_q + CNTW'(1);
      end
      ST_C_DY: dot_q <= (x1_q[DW-1] ^ x2_q[DW-1]) ? -p_dot : p_dot;
      ST_C_LP: dot_q <= dot_q + ((y1_q[DW-1] ^ y2_q[DW-1]) ? -p_dot : p_dot);
      ST_C_DEC: begin
        lpn_q <= LPW'(mul_p);
        if (take) begin
          bd_q  <= dot_q;
          blp_q <= LPW'(mul_p);
        end
        if (take || skip) ic_q <= ic_q + CNTW'(1);
      end
      ST_C_RHS1: lhs_q <= mul_p;
      ST_C_CMP: begin
        if (smaller) begin
          bd_q  <= dot_q;
          blp_q <= lpn_q;
        end
        ic_q <= ic_q + CNTW'(1);
      end
      ST_Q_SET: begin
        tgt_q  <= mul_p << 60;
        q_q    <= '0;
        qbit_q <= 5'd30;
      end
      ST_Q_T3: begin
        if (mul_p <= tgt_q) q_q <= t_val;
        qbit_q <= qbit_q - 5'd1;
      end
      ST_S_SQ: q_q <= q_clamp;
      ST_S_INIT: begin
        v_q  <= (SQ_W'(1) << 60) - SQ_W'(mul_p);
        r_q  <= '0;
        sb_q <= SQ_W'(1) << 62;
      end
      ST_S_IT: begin
        if (sq_ge) begin
          v_q <= v_q - sq_try;
          r_q <= (r_q >> 1) + sb_q;
        end else begin
          r_q <= r_q >> 1;
        end
        sb_q <= sb_q >> 2;
      end
      ST_R_INIT: begin
        // obtuse cosine: turn the vector by a quarter turn first
        if (rot) begin
          x_q <= signed'(CW'(r_q));
          y_q <= signed'(CW'(q_q));
          z_q <= HALF_PI_Q30;
        end else begin
          x_q <= signed'(CW'(q_q));
          y_q <= signed'(CW'(r_q));
          z_q <= '0;
        end
        k_q <= '0;
      end
      ST_R_IT: begin
        if (!y_q[CW-1]) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + at;
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - at;
        end
        k_q <= k_q + KW'(1);
      end
      ST_R_FIN: begin
        if (z_rnd[CW-1])                             angle_q <= '0;
        else if (z_rnd > signed'(CW'(ANGLE_MAX)))     angle_q <= ANGLE_MAX;
        else                                         angle_q <= ANGLE_W'(z_rnd);
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/max_triangle_angle_finder.sv]
// operation: one point per cycle while loading; after the final point the sequencer runs
// the search over all ordered (a, b<c) triples, about 5 to 9 multiplies per triple, each
// multiply running on the one shared 8-bit-digit multiplier,
// then 31 bisection steps of two multiplies, 32 square root steps and CORDIC_STEPS steps
// throughput: one point set at a time; the result waits in an output register
// reset: asynchronous, clears the sequencer, point count and flags; the store is not cleared
module max_triangle_angle_finder #(
  parameter int MAX_POINTS   = mtaf_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS   = mtaf_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STEPS = mtaf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mtaf_pkg::POS_W-1:0]    pos_x_i,
  input  logic [mtaf_pkg::POS_W-1:0]    pos_y_i,
  input  logic                          final_point_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mtaf_pkg::ANGLE_W-1:0]  max_angle_o,
  output logic                          too_few_o,
  output logic                          overflowed_o
);
  import mtaf_pkg::*;

  logic [COORD_MAX_W-1:0] x_ext, y_ext;
  logic       seq_ready, res_valid, res_ready, load;
  mtaf_res_t  res, out_q;
  logic       out_valid_q;

  assign x_ext      = COORD_MAX_W'(pos_x_i);
  assign y_ext      = COORD_MAX_W'(pos_y_i);
  assign in_stall_o = !seq_ready;
  assign load       = in_valid_i && seq_ready;
  assign res_ready  = !out_valid_q || !out_stall_i;

  mtaf_seq #(
    .MAX_POINTS   (MAX_POINTS),
    .COORD_BITS   (COORD_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .px_i        (x_ext[COORD_BITS-1:0]),
    .py_i        (y_ext[COORD_BITS-1:0]),
    .final_i     (final_point_i),
    .ready_o     (seq_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign max_angle_o  = out_q.angle;
  assign too_few_o    = out_q.too_few;
  assign overflowed_o = out_q.overflowed;

endmodule

[rtl/core/mtaf_checker.sv]
// port-level checks for the max triangle angle finder, bound to the top level
// depends on mtaf_pkg and max_triangle_angle_finder
module mtaf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [mtaf_pkg::POS_W-1:0]    pos_x_i,
  input logic [mtaf_pkg::POS_W-1:0]    pos_y_i,
  input logic                          final_point_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [mtaf_pkg::ANGLE_W-1:0]  max_angle_o,
  input logic                          too_few_o,
  input logic                          overflowed_o
);
  import mtaf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(max_angle_o)
      && $stable(too_few_o) && $stable(overflowed_o))
    else $error("result changed while stalled");

  // a short set reports no angle
  a_few_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_few_o |-> max_angle_o == '0)
    else $error("angle nonzero with too few points");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> max_angle_o <= ANGLE_MAX)
    else $error("angle above pi");

  // the final point transfer starts the search, no more points taken
  a_final_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && final_point_i |=> in_stall_o)
    else $error("input taken right after final point");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind max_triangle_angle_finder mtaf_checker u_mtaf_checker (.*);
